// ----- rtl/sse_pkg.sv -----
// Shared types, constants and the alphabet lookup for the sextet split encoder.
// Used by sse_regs and sextet_split_encoder; no other dependencies.
package sse_pkg;

  localparam int unsigned ALPHA_WORDS  = 8;
  localparam int unsigned ALPHA_LANES  = 8;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned CFG_ADDR_W   = 6;
  localparam int unsigned SEXTET_W     = 6;
  localparam int unsigned CHAR_W       = 8;

  // Position of the next byte within its group of three
  localparam logic [1:0] PHASE_FIRST  = 2'd0;
  localparam logic [1:0] PHASE_SECOND = 2'd1;
  localparam logic [1:0] PHASE_THIRD  = 2'd2;

  // One alphabet word: eight characters, lane 0 in bits 7:0
  typedef logic [ALPHA_LANES-1:0][CHAR_W-1:0] alpha_word_t;
  typedef alpha_word_t [ALPHA_WORDS-1:0]       alphabet_t;

  // One encoded result item
  typedef struct packed {
    logic                last;
    logic [SEXTET_W-1:0] sextet;
    logic [CHAR_W-1:0]   chr;
  } out_item_t;

  // Alphabet character for a sextet: word from bits 5:3, lane from bits 2:0
  function automatic logic [CHAR_W-1:0] map_char(input alphabet_t alpha,
                                                 input logic [SEXTET_W-1:0] s);
    return alpha[s[5:3]][s[2:0]];
  endfunction

endpackage

// ----- rtl/sextet_split_encoder.sv -----
// Top level of the sextet split encoder: byte stream in, alphabet-mapped sextets out.
// Depends on sse_pkg and sse_regs.

// Each accepted byte yields its low six bits as a symbol in the next cycle; the third
// byte of a group, or a byte marked tlast, also yields the gathered sextet of high-bit
// pairs (first byte at bits 5:4, second 3:2, third 1:0), delivered after the first
// symbol from a holding register. A byte that gives two symbols stalls input until the
// held symbol has moved to the output; the single result channel, one symbol per cycle
// while out_tready is high, sets the throughput. out_tlast marks the gathered sextet
// that ends a message. Alphabet words are loaded at byte addresses 0x00..0x38 and reset
// to zero; write them only while the stream is idle.
module sextet_split_encoder (
  input  logic        clk,
  input  logic        rst_n,
  // Input item channel
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte
  input  logic        in_tlast,    // end_of_message
  // Result item channel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] symbol_char, [13:8] sextet_value, [15:14] zero
  output logic        out_tlast,   // last_symbol
  // Configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [5:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  sse_pkg::alphabet_t  alphabet;

  logic                in_fire;
  logic                out_fire;
  logic [1:0]          top_bits;
  logic                third;
  logic                two_results;

  logic [1:0]          phase_r,      phase_nxt;
  logic [5:0]          gather_r,     gather_nxt;
  logic [5:0]          gather_sum;
  logic                out_valid_r,  out_valid_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  sse_pkg::out_item_t  out_item_r,   out_item_nxt;
  sse_pkg::out_item_t  pend_item_r,  pend_item_nxt;
  sse_pkg::out_item_t  first_item,   second_item;

  // Alphabet register file
  sse_regs u_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .psel     (cfg_psel),
    .penable  (cfg_penable),
    .pwrite   (cfg_pwrite),
    .paddr    (cfg_paddr),
    .pwdata   (cfg_pwdata),
    .prdata   (cfg_prdata),
    .pready   (cfg_pready),
    .alphabet (alphabet)
  );

  // Handshakes: take a byte when the held second symbol is gone and the output frees
  assign out_fire  = out_valid_r & out_tready;
  assign in_tready = ~pend_valid_r & (~out_valid_r | out_tready);
  assign in_fire   = in_tvalid & in_tready;

  // Gather the high-bit pair at the slot for this byte's position
  assign top_bits = in_tdata[7:6];
  assign third    = (phase_r != sse_pkg::PHASE_FIRST) && (phase_r != sse_pkg::PHASE_SECOND);

  always_comb begin
    case (phase_r)
      sse_pkg::PHASE_FIRST:  gather_sum = gather_r | {top_bits, 4'b0000};
      sse_pkg::PHASE_SECOND: gather_sum = gather_r | {2'b00, top_bits, 2'b00};
      default:               gather_sum = gather_r | {4'b0000, top_bits};
    endcase
  end

  assign two_results = third | in_tlast;

  // Result items for this byte
  always_comb begin
    first_item.last    = 1'b0;
    first_item.sextet  = in_tdata[5:0];
    first_item.chr     = sse_pkg::map_char(alphabet, in_tdata[5:0]);
    second_item.last   = in_tlast;
    second_item.sextet = gather_sum;
    second_item.chr    = sse_pkg::map_char(alphabet, gather_sum);
  end

  // Group state update
  always_comb begin
    phase_nxt  = phase_r;
    gather_nxt = gather_r;
    if (in_fire) begin
      if (two_results) begin
        phase_nxt  = sse_pkg::PHASE_FIRST;
        gather_nxt = '0;
      end else begin
        phase_nxt  = phase_r + 2'd1;
        gather_nxt = gather_sum;
      end
    end
  end

  // Output register and holding register for the second symbol
  always_comb begin
    out_valid_nxt  = out_valid_r;
    pend_valid_nxt = pend_valid_r;
    out_item_nxt   = out_item_r;
    pend_item_nxt  = pend_item_r;
    if (in_fire) begin
      out_valid_nxt  = 1'b1;
      out_item_nxt   = first_item;
      pend_valid_nxt = two_results;
      pend_item_nxt  = second_item;
    end else if (out_fire) begin
      out_valid_nxt  = pend_valid_r;
      out_item_nxt   = pend_item_r;
      pend_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= sse_pkg::PHASE_FIRST;
      gather_r     <= '0;
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      phase_r      <= phase_nxt;
      gather_r     <= gather_nxt;
      out_valid_r  <= out_valid_nxt;
      pend_valid_r <= pend_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_item_r  <= out_item_nxt;
    pend_item_r <= pend_item_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_item_r.sextet, out_item_r.chr};
  assign out_tlast  = out_item_r.last;

  // A held second symbol always sits behind a valid output
  a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> out_valid_r)
    else $error("second symbol held without a first one in the output register");

  // A byte ending a message closes its group
  a_tlast_closes_group: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> (phase_r == sse_pkg::PHASE_FIRST && gather_r == 6'd0))
    else $error("group state not cleared after end of message");

  // Nothing is queued behind the last symbol of a message
  a_last_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_tlast) |-> !pend_valid_r)
    else $error("symbol queued behind the last symbol of a message");

  // The third byte of a group always produces a second symbol
  a_third_two: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && third) |=> pend_valid_r)
    else $error("gathered sextet missing after third byte");

endmodule

// ----- rtl/sse_regs.sv -----
// Alphabet register file behind the APB-style configuration port.
// Depends on sse_pkg for widths and the alphabet type.
module sse_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sse_pkg::CFG_ADDR_W-1:0]     paddr,
  input  logic [sse_pkg::CFG_DATA_W-1:0]     pwdata,
  output logic [sse_pkg::CFG_DATA_W-1:0]     prdata,
  output logic                               pready,
  output sse_pkg::alphabet_t                 alphabet
);

  sse_pkg::alphabet_t alphabet_r;
  logic               wr_en;
  logic [2:0]         word_sel;

  // Eight 64-bit words at byte addresses 8*i
  assign word_sel = paddr[5:3];
  assign pready   = 1'b1;
  assign wr_en    = psel & penable & pwrite & pready;

  // Register writes; reset clears the alphabet to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alphabet_r <= '0;
    end else if (wr_en) begin
      alphabet_r[word_sel] <= pwdata;
    end
  end

  // Read back the addressed word
  assign prdata   = alphabet_r[word_sel];
  assign alphabet = alphabet_r;

endmodule
